// ===== hdl/tes_pkg.sv =====
package tes_pkg;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       out_last;
	} out_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_O      = 8'h6F;
	localparam logic [7:0] CH_PAREN  = 8'h28;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_ESC    = 3'd1;
	localparam logic [2:0] MODE_DELIM  = 3'd2;
	localparam logic [2:0] MODE_SKIP2  = 3'd3;
	localparam logic [2:0] MODE_SKIP1  = 3'd4;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

// ===== hdl/troff_escape_stripper_top.sv =====
// Escape stripper: removes typesetter escapes and overstrike marks from a
// character stream, one byte per word.
// Input channel item_valid/item_ready/item carries one character and a flag
// marking the last character of a string. Output channel
// result_valid/result_ready/result carries a kept character (has_char) and
// the end-of-string flag. A word that keeps nothing and is not last gives
// no result word; the last word of a string always gives one.
// Throughput: one word per cycle while the receiver takes results or the
// word gives no result. The scan mode and delimiter registers are read
// and updated in the same cycle, which sets that figure. An accepted word
// is registered in the input stage; its result is then registered in the
// result register and shown from there. Reset clears both stages and
// returns to normal mode with no overstrike. When the receiver stalls, the
// result register holds; the input stage keeps moving while its word gives
// no result, else it holds and item_ready drops.
module troff_escape_stripper_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tes_pkg::in_t      item,
	output logic              result_valid,
	input  logic              result_ready,
	output tes_pkg::out_t     result
);

	logic          s1_valid_s1;
	tes_pkg::in_t  s1_item_s1;
	logic          out_valid_q;
	tes_pkg::out_t out_data_q;
	logic [2:0]    mode_q;
	logic [7:0]    delim_q;

	logic [2:0]    mode_nx;
	logic [7:0]    delim_nx;
	logic          keep;
	logic [7:0]    oc;
	logic          produce;
	logic          out_free;
	logic          s1_go;
	logic [7:0]    c;
	logic          in_ovs;
	logic          plain_ok;

	assign c        = s1_item_s1.in_char;
	assign in_ovs   = (delim_q != 8'h00);
	assign plain_ok = !in_ovs || tes_pkg::is_letter(c);

	always_comb begin
		mode_nx  = tes_pkg::MODE_NORMAL;
		delim_nx = delim_q;
		keep     = 1'b0;
		oc       = 8'h00;
		case (mode_q)
			tes_pkg::MODE_ESC: begin
				if (in_ovs && (c == delim_q)) begin
					keep = 1'b1;
					oc   = c;
				end else if ((c == tes_pkg::CH_BSLASH) || (c == tes_pkg::CH_E)) begin
					keep = 1'b1;
					oc   = tes_pkg::CH_BSLASH;
				end else if (c == tes_pkg::CH_O) begin
					mode_nx = tes_pkg::MODE_DELIM;
				end else if (c == tes_pkg::CH_PAREN) begin
					if (in_ovs) begin
						mode_nx = tes_pkg::MODE_SKIP2;
					end else begin
						keep = 1'b1;
						oc   = c;
					end
				end else if (plain_ok) begin
					keep = 1'b1;
					oc   = c;
				end
			end
			tes_pkg::MODE_DELIM: begin
				delim_nx = c;
			end
			tes_pkg::MODE_SKIP2: begin
				mode_nx = tes_pkg::MODE_SKIP1;
			end
			tes_pkg::MODE_SKIP1: begin
				mode_nx = tes_pkg::MODE_NORMAL;
			end
			default: begin
				if (c == tes_pkg::CH_BSLASH) begin
					mode_nx = tes_pkg::MODE_ESC;
				end else if (in_ovs && (c == delim_q)) begin
					delim_nx = 8'h00;
				end else if (plain_ok) begin
					keep = 1'b1;
					oc   = c;
				end
			end
		endcase
		// end of string: back to reset state
		if (s1_item_s1.in_last) begin
			mode_nx  = tes_pkg::MODE_NORMAL;
			delim_nx = 8'h00;
		end
	end

	assign produce    = keep || s1_item_s1.in_last;
	assign out_free   = !out_valid_q || result_ready;
	assign s1_go      = s1_valid_s1 && (out_free || !produce);
	assign item_ready = !s1_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= tes_pkg::MODE_NORMAL;
			delim_q     <= 8'h00;
		end else begin
			if (item_ready) begin
				s1_valid_s1 <= item_valid;
			end
			if (s1_go) begin
				mode_q  <= mode_nx;
				delim_q <= delim_nx;
			end
			if (out_free) begin
				out_valid_q <= s1_go && produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			s1_item_s1 <= item;
		end
		if (s1_go && produce && out_free) begin
			out_data_q.out_char <= oc;
			out_data_q.has_char <= keep;
			out_data_q.out_last <= s1_item_s1.in_last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_data_q;

`ifndef NO_ASSERTIONS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_go) |=> s1_valid_s1)
		else $error("input stage word lost while stalled");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= tes_pkg::MODE_SKIP1)
		else $error("scan mode left its code range");

	a_result_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.has_char || result.out_last))
		else $error("result word with neither character nor end flag");

	a_no_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.has_char) |-> (result.out_char == 8'h00))
		else $error("empty result carries a character");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_item_s1.in_last) |=>
		((mode_q == tes_pkg::MODE_NORMAL) && (delim_q == 8'h00)))
		else $error("state not cleared after end of string");
`endif

endmodule
